>>> design/dmf_pkg.sv
// ----------------------------------------------------------------------------
// dmf_pkg
// Shared types, constants and helpers for the degenerate DNA motif finder.
// ----------------------------------------------------------------------------
package dmf_pkg;

  // Field widths
  localparam int BASE_W     = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int MASK_W     = 4;
  localparam int LEN_W      = 6;
  localparam int MASKS_W    = 2 * CFG_DATA_W;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASKS_LOW    = 2'd0,
    CFG_MASKS_HIGH   = 2'd1,
    CFG_MOTIF_LENGTH = 2'd2
  } cfg_reg_t;

  // ASCII codes of the four bases
  localparam logic [BASE_W-1:0] ASCII_A = 8'h41;
  localparam logic [BASE_W-1:0] ASCII_C = 8'h43;
  localparam logic [BASE_W-1:0] ASCII_G = 8'h47;
  localparam logic [BASE_W-1:0] ASCII_T = 8'h54;

  // One-hot base codes as used in the position masks
  localparam logic [MASK_W-1:0] BASE_BIT_A    = 4'h1;
  localparam logic [MASK_W-1:0] BASE_BIT_C    = 4'h2;
  localparam logic [MASK_W-1:0] BASE_BIT_G    = 4'h4;
  localparam logic [MASK_W-1:0] BASE_BIT_T    = 4'h8;
  localparam logic [MASK_W-1:0] BASE_BIT_NONE = 4'h0;

  // Motif settings as seen by the match core
  typedef struct packed {
    logic [MASKS_W-1:0] masks;         // position j in bits 4j+3..4j
    logic [LEN_W-1:0]   motif_length;
  } dmf_cfg_t;

  // Character to one-hot base; anything else matches nothing
  function automatic logic [MASK_W-1:0] base_onehot(input logic [BASE_W-1:0] c);
    logic [MASK_W-1:0] r;
    case (c)
      ASCII_A: r = BASE_BIT_A;
      ASCII_C: r = BASE_BIT_C;
      ASCII_G: r = BASE_BIT_G;
      ASCII_T: r = BASE_BIT_T;
      default: r = BASE_BIT_NONE;
    endcase
    return r;
  endfunction

endpackage

>>> design/dmf_ifs.sv
// ----------------------------------------------------------------------------
// dmf interfaces
// Valid/ready channels for characters, results and configuration writes.
// ----------------------------------------------------------------------------

// Sequence characters in
interface dmf_char_if
  import dmf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BASE_W-1:0] base;
  logic              end_of_sequence;

  modport source (output valid, base, end_of_sequence, input ready);
  modport sink   (input valid, base, end_of_sequence, output ready);
endinterface

// Match results out
interface dmf_result_if;
  logic valid;
  logic ready;
  logic found;

  modport source (output valid, found, input ready);
  modport sink   (input valid, found, output ready);
endinterface

// Register writes
interface dmf_cfg_if
  import dmf_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/dmf_cfg_regs.sv
// ----------------------------------------------------------------------------
// dmf_cfg_regs
// Configuration register file: two mask words and the motif length.
// ----------------------------------------------------------------------------
module dmf_cfg_regs
  import dmf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  dmf_cfg_if.sink      cfg,
  output dmf_cfg_t     settings
);

  logic [CFG_DATA_W-1:0] masks_low;
  logic [CFG_DATA_W-1:0] masks_high;
  logic [LEN_W-1:0]      motif_length;

  // Writes are always taken; unknown indexes are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      masks_low    <= '0;
      masks_high   <= '0;
      motif_length <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_MASKS_LOW:    masks_low    <= cfg.data;
        CFG_MASKS_HIGH:   masks_high   <= cfg.data;
        CFG_MOTIF_LENGTH: motif_length <= cfg.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign settings.masks        = {masks_high, masks_low};
  assign settings.motif_length = motif_length;

endmodule

>>> design/dmf_match_core.sv
// ----------------------------------------------------------------------------
// dmf_match_core
// Shift-and partial-match vector and hit flag, one character per cycle while take is set.
// ----------------------------------------------------------------------------
module dmf_match_core
  import dmf_pkg::*;
#(
  parameter int MAX_POSITIONS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [BASE_W-1:0] base,
  input  logic              end_of_sequence,
  input  dmf_cfg_t          settings,
  output logic              found_next
);

  logic [MAX_POSITIONS-1:0] partial_matches;
  logic [MAX_POSITIONS-1:0] partial_matches_next;
  logic [MAX_POSITIONS-1:0] column;
  logic                     seen_match;
  logic                     seen_match_next;
  logic                     hit;
  logic [LEN_W-1:0]         len;
  logic [MASK_W-1:0]        dm;

  // Clamp length to the number of positions built
  always_comb begin
    if (settings.motif_length > LEN_W'(MAX_POSITIONS)) begin
      len = LEN_W'(MAX_POSITIONS);
    end else begin
      len = settings.motif_length;
    end
  end

  assign dm = base_onehot(base);

  // Positions that accept this character, limited to the active length
  always_comb begin
    for (int j = 0; j < MAX_POSITIONS; j++) begin
      column[j] = (|(settings.masks[MASK_W*j +: MASK_W] & dm)) && (LEN_W'(j) < len);
    end
  end

  assign partial_matches_next =
    ((partial_matches << 1) | MAX_POSITIONS'(1'b1)) & column;

  // Full match when the bit of the last position is set
  always_comb begin
    hit = 1'b0;
    for (int j = 0; j < MAX_POSITIONS; j++) begin
      if (partial_matches_next[j] && (LEN_W'(j + 1) == len)) begin
        hit = 1'b1;
      end
    end
  end

  assign seen_match_next = seen_match | hit;
  assign found_next      = seen_match_next;

  // State update; cleared after the last character of a sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_matches <= '0;
      seen_match      <= 1'b0;
    end else if (take) begin
      if (end_of_sequence) begin
        partial_matches <= '0;
        seen_match      <= 1'b0;
      end else begin
        partial_matches <= partial_matches_next;
        seen_match      <= seen_match_next;
      end
    end
  end

endmodule

>>> design/degenerate_dna_motif_finder_top.sv
// ----------------------------------------------------------------------------
// degenerate_dna_motif_finder_top
// Streams DNA characters and reports per sequence whether a degenerate
// motif occurred.
// ----------------------------------------------------------------------------
// One character is taken every cycle unless the channel stalls: the shift-and
// update of the partial-match register is a single combinational step. The
// result of a sequence appears in the output register in the cycle after its
// last character is taken and stays there until the consumer takes it; the
// character channel only stalls while a result sits in that register
// unaccepted. The user must set motif masks and length by register writes
// only while no sequence is in flight; the block does not enforce this.
module degenerate_dna_motif_finder_top
  import dmf_pkg::*;
#(
  parameter int MAX_POSITIONS = 32
) (
  input  logic         clk,
  input  logic         rst,
  dmf_char_if.sink     chars,
  dmf_result_if.source result,
  dmf_cfg_if.sink      cfg
);

  dmf_cfg_t settings;
  logic     take;
  logic     found_next;
  logic     result_valid;
  logic     found;

  // Plain copies of the handshake for the bound checker
  logic     chk_in_valid;
  logic     chk_in_ready;
  logic     chk_in_eos;
  logic     chk_out_valid;
  logic     chk_out_ready;
  logic     chk_found;

  dmf_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .settings (settings)
  );

  dmf_match_core #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_match_core (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .base            (chars.base),
    .end_of_sequence (chars.end_of_sequence),
    .settings        (settings),
    .found_next      (found_next)
  );

  // Input stalls only while a result waits
  assign chars.ready = !result_valid || result.ready;
  assign take        = chars.valid && chars.ready;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take && chars.end_of_sequence) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && chars.end_of_sequence) begin
      found <= found_next;
    end
  end

  assign result.valid = result_valid;
  assign result.found = found;

  assign chk_in_valid  = chars.valid;
  assign chk_in_ready  = chars.ready;
  assign chk_in_eos    = chars.end_of_sequence;
  assign chk_out_valid = result.valid;
  assign chk_out_ready = result.ready;
  assign chk_found     = result.found;

endmodule

>>> design/dmf_checker.sv
// ----------------------------------------------------------------------------
// dmf_checker
// Port-level assertions for the motif finder, bound to the top level.
// ----------------------------------------------------------------------------
module dmf_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_eos,
  input logic out_valid,
  input logic out_ready,
  input logic found
);

  // A held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A held result keeps its value
  a_found_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(found))
    else $error("result changed while stalled");

  // Last character of a sequence yields a result next cycle
  a_eos_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_eos |=> out_valid)
    else $error("no result after end of sequence");

  // Other characters create no result
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && in_ready && in_eos) && !(out_valid && !out_ready) |=> !out_valid)
    else $error("result without end of sequence");

  // Input stalls only behind a waiting result
  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without cause");

endmodule

bind degenerate_dna_motif_finder_top dmf_checker u_dmf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (chk_in_valid),
  .in_ready  (chk_in_ready),
  .in_eos    (chk_in_eos),
  .out_valid (chk_out_valid),
  .out_ready (chk_out_ready),
  .found     (chk_found)
);

>>> tb/motif_match_checker.sv
// ----------------------------------------------------------------------------
// motif_match_checker
// Watches the character, result and register-write channels of the motif
// finder, tracks the shift-and match state itself and compares every found
// flag that leaves the block against its own verdict for that sequence.
// ----------------------------------------------------------------------------
module motif_match_checker
  import dmf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  input  logic                  char_ready,
  input  logic [BASE_W-1:0]     base,
  input  logic                  end_of_sequence,
  input  logic                  result_valid,
  input  logic                  result_ready,
  input  logic                  found,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding,
  output int                    sequences_judged,
  output int                    motif_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MOTIF_SLOTS = 32;

  // Own copy of the motif settings and match state
  logic [MASKS_W-1:0]     position_sets;
  logic [LEN_W-1:0]       motif_len;
  logic [MOTIF_SLOTS-1:0] partials;
  logic                   seen_hit;
  logic                   verdicts_due [$];

  // Positions in use; anything above the slot count is clamped
  function automatic int active_positions();
    return (motif_len > MOTIF_SLOTS) ? MOTIF_SLOTS : int'(motif_len);
  endfunction

  // One shift-and step: extend every partial match by this character
  function automatic logic [MOTIF_SLOTS-1:0] shift_and_step(
    input logic [MOTIF_SLOTS-1:0] vec,
    input logic [BASE_W-1:0]      ch
  );
    logic [MASK_W-1:0]      hit;
    logic [MOTIF_SLOTS-1:0] column;
    logic [MOTIF_SLOTS:0]   keep;
    int                     n;
    hit = {ch == ASCII_T, ch == ASCII_G, ch == ASCII_C, ch == ASCII_A};
    n = active_positions();
    column = '0;
    for (int j = 0; j < MOTIF_SLOTS; j++) begin
      if (j < n && (position_sets[MASK_W*j +: MASK_W] & hit) != '0)
        column[j] = 1'b1;
    end
    keep = ({{MOTIF_SLOTS{1'b0}}, 1'b1} << n) - 1'b1;
    return ((vec << 1) | 1'b1) & column & keep[MOTIF_SLOTS-1:0];
  endfunction

  always @(posedge clk) begin : watch
    logic want;
    int   n;
    if (rst) begin
      position_sets    = '0;
      motif_len        = '0;
      partials         = '0;
      seen_hit         = 1'b0;
      verdicts_due.delete();
      mismatches       = 0;
      outstanding      = 0;
      sequences_judged = 0;
      motif_hits       = 0;
    end else begin
      // Result transaction against the oldest verdict
      if (result_valid && result_ready) begin
        if (verdicts_due.size() == 0) begin
          $error("found: no result expected, got %0b", found);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          sequences_judged++;
          if (want) motif_hits++;
          if (found !== want) begin
            $error("found: expected %0b, got %0b", want, found);
            mismatches++;
          end
        end
      end

      // Register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MASKS_LOW:    position_sets[CFG_DATA_W-1:0]       = cfg_data;
          CFG_MASKS_HIGH:   position_sets[MASKS_W-1:CFG_DATA_W] = cfg_data;
          CFG_MOTIF_LENGTH: motif_len                           = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end

      // Character transaction; a verdict falls due on the last one
      if (char_valid && char_ready) begin
        n = active_positions();
        partials = shift_and_step(partials, base);
        if (n > 0 && partials[n-1]) seen_hit = 1'b1;
        if (end_of_sequence) begin
          verdicts_due.insert(verdicts_due.size(), seen_hit);
          partials = '0;
          seen_hit = 1'b0;
        end
      end

      outstanding = verdicts_due.size();
    end
  end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams directed and random DNA sequences through the motif finder under
// a range of motif settings and back-pressure patterns; the checker beside
// the block judges every result.
// ----------------------------------------------------------------------------
module testbench
  import dmf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTINGS_RUN = 12;
  localparam int CHARS_PER_SETTING = 100;
  localparam int STRAND_MAX = 64;

  logic clk = 1'b0;
  logic rst;

  dmf_char_if   chars_if ();
  dmf_result_if result_if ();
  dmf_cfg_if    cfg_if ();

  int mismatches, outstanding, sequences_judged, motif_hits;
  int tx_idle, rx_idle;
  int chars_sent, settings_loaded;

  logic [MASKS_W-1:0] cur_masks;
  logic [LEN_W-1:0]   cur_len;

  int motif_lengths [SETTINGS_RUN] = '{1, 32, 6, 0, 63, 4, 32, 2, 17, 9, 33, 12};

  degenerate_dna_motif_finder_top dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  motif_match_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .char_valid       (chars_if.valid),
    .char_ready       (chars_if.ready),
    .base             (chars_if.base),
    .end_of_sequence  (chars_if.end_of_sequence),
    .result_valid     (result_if.valid),
    .result_ready     (result_if.ready),
    .found            (result_if.found),
    .cfg_valid        (cfg_if.valid),
    .cfg_ready        (cfg_if.ready),
    .cfg_index        (cfg_if.index),
    .cfg_data         (cfg_if.data),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .sequences_judged (sequences_judged),
    .motif_hits       (motif_hits)
  );

  // Clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result consumer with random stalls
  always @(posedge clk) begin
    result_if.ready <= rst ? 1'b0 : ($urandom_range(99) >= rx_idle);
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [BASE_W-1:0] letter(input int k);
    case (k)
      0:       return ASCII_A;
      1:       return ASCII_C;
      2:       return ASCII_G;
      default: return ASCII_T;
    endcase
  endfunction

  // Half letters, half arbitrary bytes
  function automatic logic [BASE_W-1:0] noise_byte();
    if ($urandom_range(1)) return letter($urandom_range(3));
    return BASE_W'($urandom_range(255));
  endfunction

  // A base allowed by this position's mask; any letter if none is
  function automatic logic [BASE_W-1:0] pick_base(input logic [MASK_W-1:0] m);
    int k;
    if (m == '0) return letter($urandom_range(3));
    do k = $urandom_range(3); while (!m[k]);
    return letter(k);
  endfunction

  function automatic int clamp_len(input logic [LEN_W-1:0] n);
    return (n > 32) ? 32 : int'(n);
  endfunction

  // Three register writes back to back, valid lowered once at the end
  task automatic load_motif(input logic [MASKS_W-1:0] masks, input logic [LEN_W-1:0] len);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_MASKS_LOW;
    cfg_if.data  <= masks[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.index <= CFG_MASKS_HIGH;
    cfg_if.data  <= masks[MASKS_W-1:CFG_DATA_W];
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.index <= CFG_MOTIF_LENGTH;
    cfg_if.data  <= CFG_DATA_W'(len);
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cur_masks = masks;
    cur_len   = len;
    settings_loaded++;
  endtask

  // One character transaction, with random idle cycles before it
  task automatic send_char(input logic [BASE_W-1:0] b, input logic last);
    while ($urandom_range(99) < tx_idle) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
    chars_if.valid           <= 1'b1;
    chars_if.base            <= b;
    chars_if.end_of_sequence <= last;
    do @(posedge clk); while (!chars_if.ready);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Stop sending and wait until every verdict has been taken
  task automatic drain();
    chars_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Mostly sequences carrying a motif instance, some broken, some noise
  task automatic send_random_sequence();
    logic [BASE_W-1:0] strand [STRAND_MAX];
    int n, span, start, kind, slip;
    n = clamp_len(cur_len);
    kind = $urandom_range(9);
    if ($urandom_range(19) == 0) span = $urandom_range(n + 30, 1);
    else span = $urandom_range(n + 6, 1);
    for (int i = 0; i < span; i++)
      strand[i] = kind >= 8 ? noise_byte() : letter($urandom_range(3));
    if (kind < 8 && n > 0 && span >= n) begin
      start = $urandom_range(span - n);
      for (int j = 0; j < n; j++)
        strand[start + j] = pick_base(cur_masks[MASK_W*j +: MASK_W]);
      if (kind == 7) begin
        slip = $urandom_range(n - 1);
        strand[start + slip] = noise_byte();
      end
    end
    for (int i = 0; i < span; i++) send_char(strand[i], i == span - 1);
  endtask

  initial begin
    logic [MASKS_W-1:0] masks;
    int                 first_char;
    bit                 paused;

    rst                      <= 1'b1;
    chars_if.valid           <= 1'b0;
    chars_if.base            <= '0;
    chars_if.end_of_sequence <= 1'b0;
    cfg_if.valid             <= 1'b0;
    cfg_if.index             <= CFG_MASKS_LOW;
    cfg_if.data              <= '0;
    tx_idle = 0;
    rx_idle = 0;
    chars_sent = 0;
    settings_loaded = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: exact motif ACGT
    load_motif(MASKS_W'(64'h8421), 6'd4);
    send_text("ACGT");
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("ACG");
    // sequence shorter than the motif
    send_text("AC");
    // lowercase breaks the run, a later clean run still hits
    send_text("ACgACGT");

    // Directed: zero length never matches
    drain();
    repeat (4) @(posedge clk);
    load_motif(MASKS_W'(64'h8421), 6'd0);
    send_text("ACGT");

    // Random phases: sender mostly busy, receiver slow; then swapped; then free
    for (int k = 0; k < SETTINGS_RUN; k++) begin
      tx_idle = (k < 4) ? 8 : (k < 8) ? 85 : 0;
      rx_idle = (k < 4) ? 85 : (k < 8) ? 8 : 0;
      if (k == 1) masks = '1;
      else if (k == 7) masks = '0;
      else if (k % 2 == 1) begin
        for (int j = 0; j < 32; j++)
          masks[MASK_W*j +: MASK_W] = MASK_W'(1) << $urandom_range(3);
      end else masks = {$urandom, $urandom, $urandom, $urandom};
      drain();
      repeat (4) @(posedge clk);
      load_motif(masks, LEN_W'(motif_lengths[k]));
      first_char = chars_sent;
      paused = 1'b0;
      while (chars_sent - first_char < CHARS_PER_SETTING) begin
        // hold off once mid-phase until the block has handed everything over
        if (!paused && chars_sent - first_char >= CHARS_PER_SETTING / 2) begin
          drain();
          paused = 1'b1;
        end
        send_random_sequence();
      end
    end

    drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d characters in %0d sequences under %0d motif settings;",
             chars_sent, sequences_judged, settings_loaded);
    $display("%0d of those sequences held the motif.", motif_hits);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
